>>> rtl/core/w2s_pkg.sv
// ---------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package w2s_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int FOCAL_FRAC    = 16;
  localparam int QBITS         = 41;   // quotient bits, ratio clamp at 2^40
  localparam int MAG_W         = 64;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_FOCAL_X = 2'd2;
  localparam logic [1:0] REG_FOCAL_Y = 2'd3;

  localparam logic [1:0] VEC_RIGHT   = 2'd0;
  localparam logic [1:0] VEC_UP      = 2'd1;
  localparam logic [1:0] VEC_FORWARD = 2'd2;
  localparam logic [1:0] VEC_ORIGIN  = 2'd3;

  localparam logic       KIND_LOAD   = 1'b0;
  localparam logic       KIND_PROJ   = 1'b1;

  localparam logic [13:0] WIDTH_RST  = 14'd1920;
  localparam logic [13:0] HEIGHT_RST = 14'd1080;
  localparam logic [23:0] FOCAL_RST  = 24'd65536;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] dr;
    logic signed [31:0] du;
    logic signed [31:0] df;
  } dot_t;

endpackage
`default_nettype wire

>>> rtl/core/w2s_dot.sv
// ---------------------------------------------------------------------------
// w2s_dot
// Delta from origin and the three dot products, three register stages.
// ---------------------------------------------------------------------------
`default_nettype none
module w2s_dot #(
  parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                take,
  input  wire logic signed [31:0]  px,
  input  wire logic signed [31:0]  py,
  input  wire logic signed [31:0]  pz,
  input  wire logic [11:0][31:0]   basis,
  output w2s_pkg::dot_t            dot
);

  localparam logic signed [64:0] ONE_M1 = (65'sd1 <<< FRAC_BITS) - 65'sd1;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [64:0] trunc_sh(input logic signed [63:0] p);
    logic signed [64:0] e;
    e = {p[63], p};
    if (p[63]) e = e + ONE_M1;
    return e >>> FRAC_BITS;
  endfunction

  logic               v1_r, v2_r, v3_r;
  logic signed [31:0] d_r [3];
  logic signed [31:0] b_r [9];
  logic signed [63:0] pr_r [9];
  logic signed [31:0] s_r [3];
  logic signed [31:0] d_nxt [3];
  logic signed [31:0] s_nxt [3];
  logic signed [32:0] diff [3];
  logic signed [64:0] tq [9];

  always_comb begin
    diff[0] = {px[31], px} - {basis[9][31], basis[9]};
    diff[1] = {py[31], py} - {basis[10][31], basis[10]};
    diff[2] = {pz[31], pz} - {basis[11][31], basis[11]};
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = sat32({{33{diff[i][32]}}, diff[i]});
    end
    for (int j = 0; j < 9; j++) begin
      tq[j] = trunc_sh(pr_r[j]);
    end
    for (int v = 0; v < 3; v++) begin
      s_nxt[v] = sat32({tq[3*v][64], tq[3*v]}
                     + {tq[3*v+1][64], tq[3*v+1]}
                     + {tq[3*v+2][64], tq[3*v+2]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) d_r[i] <= d_nxt[i];
      for (int j = 0; j < 9; j++) b_r[j] <= basis[j];
      for (int j = 0; j < 9; j++) pr_r[j] <= d_r[j % 3] * b_r[j];
      for (int v = 0; v < 3; v++) s_r[v] <= s_nxt[v];
    end
  end

  assign dot.valid = v3_r;
  assign dot.dr    = s_r[0];
  assign dot.du    = s_r[1];
  assign dot.df    = s_r[2];

endmodule
`default_nettype wire

>>> rtl/core/w2s_div.sv
// ---------------------------------------------------------------------------
// w2s_div
// Pipelined restoring divider, one quotient bit per stage, clamped at 2^40.
// ---------------------------------------------------------------------------
`default_nettype none
module w2s_div #(
  parameter int TAG_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_v,
  input  wire logic [w2s_pkg::MAG_W-1:0]     mag,
  input  wire logic [31:0]                   den,
  input  wire logic [TAG_W-1:0]              tag_in,
  output logic                               out_v,
  output logic [w2s_pkg::QBITS-1:0]          quo,
  output logic [TAG_W-1:0]                   tag_out
);

  localparam int QB = w2s_pkg::QBITS;
  localparam int HB = w2s_pkg::MAG_W - QB;
  localparam logic [QB-1:0] LIMIT = {1'b1, {(QB-1){1'b0}}};

  logic             v_r   [QB+1];
  logic [31:0]      rem_r [QB+1];
  logic [31:0]      den_r [QB+1];
  logic [QB-1:0]    low_r [QB+1];
  logic [QB-1:0]    q_r   [QB+1];
  logic             ovf_r [QB+1];
  logic [TAG_W-1:0] tag_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {{(32-HB){1'b0}}, mag[w2s_pkg::MAG_W-1:QB]};
      ovf_r[0] <= ({{(32-HB){1'b0}}, mag[w2s_pkg::MAG_W-1:QB]} >= den);
      den_r[0] <= den;
      low_r[0] <= mag[QB-1:0];
      q_r[0]   <= '0;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [32:0] trial;
    logic        ge;
    logic [31:0] rem_nxt;
    always_comb begin
      trial   = {rem_r[k-1], low_r[k-1][QB-k]};
      ge      = trial >= {1'b0, den_r[k-1]};
      rem_nxt = ge ? 32'(trial - {1'b0, den_r[k-1]}) : trial[31:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_r[k-1];
        low_r[k] <= low_r[k-1];
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  assign out_v   = v_r[QB];
  assign quo     = (ovf_r[QB] || q_r[QB] > LIMIT) ? LIMIT : q_r[QB];
  assign tag_out = tag_r[QB];

endmodule
`default_nettype wire

>>> rtl/core/world_to_screen_projection_unit.sv
// ---------------------------------------------------------------------------
// world_to_screen_projection_unit
// Perspective projection of world points to Q16.16 screen coordinates.
// ---------------------------------------------------------------------------
// Input channel (in_*): valid/stall. kind 0 loads one camera vector
// (right, up, forward, origin) and gives no result; kind 1 projects a point
// and gives exactly one result on the out_* channel.
// APB-style port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// screen width, height and the two focal scales; write only when idle.
// Throughput: one item per cycle unless out_stall holds a waiting result. A
// projection passes through the dot-product, multiplier, divider (for the
// depth division) and output stages.
// A load takes effect at its transfer; projections already accepted keep
// the camera they saw.
// When out_stall holds a waiting result the whole pipeline freezes and
// in_stall is raised; nothing is lost or repeated.
// Reset clears the camera to zero (all points not visible), restores the
// register defaults and empties the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module world_to_screen_projection_unit #(
  parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [1:0]         in_vector_select,
  input  wire logic signed [31:0] in_coord_x,
  input  wire logic signed [31:0] in_coord_y,
  input  wire logic signed [31:0] in_coord_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_visible,
  output logic signed [31:0]      out_screen_x,
  output logic signed [31:0]      out_screen_y,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int SH = FRAC_BITS - w2s_pkg::FOCAL_FRAC;
  localparam int QB = w2s_pkg::QBITS;
  localparam logic signed [42:0] ONE = 43'sd1 <<< FRAC_BITS;

  logic [13:0]        width_r, height_r;
  logic [23:0]        fx_r, fy_r;
  logic [11:0][31:0]  cam_r;
  logic               en, take, load;
  w2s_pkg::dot_t      dot;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign take     = in_valid && en && (in_kind == w2s_pkg::KIND_PROJ);
  assign load     = in_valid && en && (in_kind == w2s_pkg::KIND_LOAD);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= w2s_pkg::WIDTH_RST;
      height_r <= w2s_pkg::HEIGHT_RST;
      fx_r     <= w2s_pkg::FOCAL_RST;
      fy_r     <= w2s_pkg::FOCAL_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        w2s_pkg::REG_WIDTH:   width_r  <= pwdata[13:0];
        w2s_pkg::REG_HEIGHT:  height_r <= pwdata[13:0];
        w2s_pkg::REG_FOCAL_X: fx_r     <= pwdata[23:0];
        w2s_pkg::REG_FOCAL_Y: fy_r     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      w2s_pkg::REG_WIDTH:   prdata = {18'd0, width_r};
      w2s_pkg::REG_HEIGHT:  prdata = {18'd0, height_r};
      w2s_pkg::REG_FOCAL_X: prdata = {8'd0, fx_r};
      w2s_pkg::REG_FOCAL_Y: prdata = {8'd0, fy_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r <= '0;
    end else if (load) begin
      case (in_vector_select)
        w2s_pkg::VEC_RIGHT:   cam_r[2:0]  <= {in_coord_z, in_coord_y, in_coord_x};
        w2s_pkg::VEC_UP:      cam_r[5:3]  <= {in_coord_z, in_coord_y, in_coord_x};
        w2s_pkg::VEC_FORWARD: cam_r[8:6]  <= {in_coord_z, in_coord_y, in_coord_x};
        w2s_pkg::VEC_ORIGIN:  cam_r[11:9] <= {in_coord_z, in_coord_y, in_coord_x};
        default: ;
      endcase
    end
  end

  w2s_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .take  (take),
    .px    (in_coord_x),
    .py    (in_coord_y),
    .pz    (in_coord_z),
    .basis (cam_r),
    .dot   (dot)
  );

  // depth and focal products
  logic        v4_r, vis4_r, sx4_r, sy4_r;
  logic [31:0] z4_r;
  logic [55:0] mx4_r, my4_r;
  logic [31:0] ax, ay;
  logic [32:0] zf;

  always_comb begin
    ax = dot.dr[31] ? 32'(-{dot.dr[31], dot.dr}) : dot.dr;
    ay = dot.du[31] ? 32'(-{dot.du[31], dot.du}) : dot.du;
    zf = 33'(-{dot.df[31], dot.df});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= dot.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis4_r <= dot.df[31];
      z4_r   <= zf[31:0];
      sx4_r  <= dot.dr[31];
      sy4_r  <= dot.du[31];
      mx4_r  <= ax * fx_r;
      my4_r  <= ay * fy_r;
    end
  end

  logic [63:0] magx, magy;
  always_comb begin
    if (SH >= 0) begin
      magx = {8'd0, mx4_r} << SH;
      magy = {8'd0, my4_r} << SH;
    end else begin
      magx = {8'd0, mx4_r} >> (-SH);
      magy = {8'd0, my4_r} >> (-SH);
    end
  end

  logic          dvx, dvy;
  logic [QB-1:0] qx, qy;
  logic [1:0]    tagx;
  logic          tagy;

  w2s_div #(.TAG_W(2)) u_div_x (
    .clk (clk), .rst_n (rst_n), .en (en), .in_v (v4_r),
    .mag (magx), .den (z4_r), .tag_in ({vis4_r, sx4_r}),
    .out_v (dvx), .quo (qx), .tag_out (tagx)
  );

  w2s_div #(.TAG_W(1)) u_div_y (
    .clk (clk), .rst_n (rst_n), .en (en), .in_v (v4_r),
    .mag (magy), .den (z4_r), .tag_in (sy4_r),
    .out_v (dvy), .quo (qy), .tag_out (tagy)
  );

  // scale by extent
  logic               v6_r, vis6_r;
  logic signed [57:0] px6_r, py6_r;
  logic signed [42:0] rx, ry, tx, ty;

  always_comb begin
    rx = tagx[0] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    ry = tagy    ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
    tx = ONE + rx;
    ty = ONE - ry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= dvx && dvy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis6_r <= tagx[1];
      px6_r  <= tx * $signed({1'b0, width_r});
      py6_r  <= ty * $signed({1'b0, height_r});
    end
  end

  function automatic logic signed [31:0] half_sat(input logic signed [57:0] p);
    logic signed [57:0] h;
    logic signed [31:0] r;
    h = (p + $signed({57'd0, p[57]})) >>> 1;
    if (h > 58'sd2147483647)       r = 32'sh7fffffff;
    else if (h < -58'sd2147483648) r = 32'sh80000000;
    else                           r = h[31:0];
    return r;
  endfunction

  logic               out_valid_r, out_vis_r;
  logic signed [31:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r <= vis6_r;
      out_x_r   <= vis6_r ? half_sat(px6_r) : 32'sd0;
      out_y_r   <= vis6_r ? half_sat(py6_r) : 32'sd0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = out_vis_r;
  assign out_screen_x = out_x_r;
  assign out_screen_y = out_y_r;

endmodule
`default_nettype wire

>>> rtl/core/w2s_checker.sv
// ---------------------------------------------------------------------------
// w2s_checker
// Port-level checks on the projection unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module w2s_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_visible,
  input wire logic signed [31:0] out_screen_x,
  input wire logic signed [31:0] out_screen_y,
  input wire logic               pready
);

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall not tied to a held result");

  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_visible) |-> (out_screen_x == 32'sd0 && out_screen_y == 32'sd0))
    else $error("hidden point with nonzero coordinates");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_screen_x) && $stable(out_screen_y)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind world_to_screen_projection_unit w2s_checker u_w2s_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_visible  (out_visible),
  .out_screen_x (out_screen_x),
  .out_screen_y (out_screen_y),
  .pready       (pready)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// World-to-screen projection unit testbench
// Drives camera loads and point projections under bursty input and a
// stalling receiver, programmes the screen registers over the APB-style port,
// and checks every projected result against a Q16.16 projection predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int  ONE          = 65536;
  localparam int  DRAIN_CYCLES = 60;
  localparam int  IDLE_LIMIT   = 3000;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } proj_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = w2s_pkg::KIND_LOAD;
  logic [1:0]         in_vector_select = w2s_pkg::VEC_RIGHT;
  logic signed [31:0] in_coord_x = '0;
  logic signed [31:0] in_coord_y = '0;
  logic signed [31:0] in_coord_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_visible;
  logic signed [31:0] out_screen_x;
  logic signed [31:0] out_screen_y;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic signed [31:0] camera [12];
  logic [13:0]        scr_w;
  logic [13:0]        scr_h;
  logic [23:0]        foc_x;
  logic [23:0]        foc_y;
  proj_t              pending_q [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 stall_pct = 0;
  int                 stall_cnt = 0;
  int                 hold_cnt = 0;
  bit                 hold_req = 1'b0;

  world_to_screen_projection_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint sat32(longint v);
    if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
    if (v < -longint'(32'sh7FFFFFFF) - 1) return -longint'(32'sh7FFFFFFF) - 1;
    return v;
  endfunction

  function automatic longint dot_basis(longint d [3], int base);
    longint acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += (d[i] * longint'(camera[base + i])) / ONE;
    return sat32(acc);
  endfunction

  function automatic longint screen_axis(longint dv, logic [23:0] focal, longint z,
                                         logic [13:0] extent, bit plus);
    longint unsigned mag;
    longint ratio, t;
    mag = longint'(dv < 0 ? -dv : dv) * longint'({40'd0, focal});
    mag = mag / longint'(z);
    if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
    ratio = dv < 0 ? -longint'(mag) : longint'(mag);
    t = plus ? ONE + ratio : ONE - ratio;
    return sat32((t * longint'({50'd0, extent})) / 2);
  endfunction

  function automatic proj_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [31:0] pz);
    longint d [3];
    longint z;
    proj_t r;
    d[0] = sat32(longint'(px) - longint'(camera[9]));
    d[1] = sat32(longint'(py) - longint'(camera[10]));
    d[2] = sat32(longint'(pz) - longint'(camera[11]));
    z = -dot_basis(d, 6);
    r = '0;
    if (z > 0) begin
      r.visible = 1'b1;
      r.sx = 32'(screen_axis(dot_basis(d, 0), foc_x, z, scr_w, 1'b1));
      r.sy = 32'(screen_axis(dot_basis(d, 3), foc_y, z, scr_h, 1'b0));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  // input transfer; valid stays high for back-to-back items
  task automatic send_item(logic kind, logic [1:0] sel, logic signed [31:0] x,
                           logic signed [31:0] y, logic signed [31:0] z);
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_vector_select = sel;
    in_coord_x = x;
    in_coord_y = y;
    in_coord_z = z;
    do @(posedge clk); while (in_stall);
    if (kind == w2s_pkg::KIND_LOAD) begin
      camera[sel * 3] = x;
      camera[sel * 3 + 1] = y;
      camera[sel * 3 + 2] = z;
    end else begin
      pending_q.push_back(project_point(x, y, z));
    end
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_idle();
    pause_input(1);
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      w2s_pkg::REG_WIDTH:   scr_w = value[13:0];
      w2s_pkg::REG_HEIGHT:  scr_h = value[13:0];
      w2s_pkg::REG_FOCAL_X: foc_x = value[23:0];
      w2s_pkg::REG_FOCAL_Y: foc_y = value[23:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_screen(int w, int h, int fx, int fy);
    wait_idle();
    cfg_write(w2s_pkg::REG_WIDTH, w);
    cfg_write(w2s_pkg::REG_HEIGHT, h);
    cfg_write(w2s_pkg::REG_FOCAL_X, fx);
    cfg_write(w2s_pkg::REG_FOCAL_Y, fy);
  endtask

  task automatic load_std_camera(logic signed [31:0] ox, logic signed [31:0] oy,
                                 logic signed [31:0] oz);
    send_item(w2s_pkg::KIND_LOAD, w2s_pkg::VEC_RIGHT, ONE, 0, 0);
    send_item(w2s_pkg::KIND_LOAD, w2s_pkg::VEC_UP, 0, ONE, 0);
    send_item(w2s_pkg::KIND_LOAD, w2s_pkg::VEC_FORWARD, 0, 0, -ONE);
    send_item(w2s_pkg::KIND_LOAD, w2s_pkg::VEC_ORIGIN, ox, oy, oz);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return $signed($urandom_range(0, 2 * 64 * ONE)) - 64 * ONE;
      default: return $signed($urandom_range(0, 2 * 1024 * ONE)) - 1024 * ONE;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_depth();
    if ($urandom_range(0, 9) == 0) return $signed($urandom_range(0, 8 * ONE));
    return -$signed($urandom_range(1, 4096 * ONE));
  endfunction

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", out_screen_x, 0);
      end else begin
        proj_t e;
        e = pending_q.pop_front();
        if (out_visible !== e.visible) report_mismatch("visible", out_visible, e.visible);
        if (out_screen_x !== e.sx) report_mismatch("screen_x", out_screen_x, e.sx);
        if (out_screen_y !== e.sy) report_mismatch("screen_y", out_screen_y, e.sy);
      end
    end
  end

  // receiver stall pattern with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (stall_cnt == 0) begin
      stall_cnt = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_cnt--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall = 1'b1;
    end else begin
      out_stall = $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic test_unloaded_camera();
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, ONE, ONE, -ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_ORIGIN, 32'sh7FFFFFFF, 32'sh80000000,
              32'sh7FFFFFFF);
  endtask

  task automatic test_directed();
    load_std_camera(0, 0, 0);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 0, 0, -ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, ONE / 2, -ONE / 2, -2 * ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, ONE, ONE, 0);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, ONE, ONE, ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 32'sh7FFFFFFF, 32'sh80000000, -1);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh80000000);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
              32'sh7FFFFFFF);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, -1, -1, -1);
    load_std_camera(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_UP, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh80000000);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_FORWARD, 0, 0, 0);
    load_std_camera(ONE, 2 * ONE, 3 * ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, ONE, 2 * ONE, ONE);
  endtask

  task automatic test_screen_settings();
    set_screen(0, 0, 65536, 65536);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 5 * ONE, -3 * ONE, -ONE);
    set_screen(16383, 8192, 24'hFFFFFF, 0);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 5 * ONE, -3 * ONE, -ONE);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 32'sh7FFFFFFF, 32'sh80000000, ONE);
    set_screen(1, 1, 0, 24'hFFFFFF);
    send_item(w2s_pkg::KIND_PROJ, w2s_pkg::VEC_RIGHT, 5 * ONE, -3 * ONE, -ONE);
    set_screen(1280, 720, 81920, 123456);
  endtask

  task automatic test_random(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
      end
      burst--;
      if (i % 100 == 50) begin
        set_screen($urandom_range(0, 16383), $urandom_range(0, 16383),
                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 4 * ONE));
      end
      case ($urandom_range(0, 19))
        0: send_item(w2s_pkg::KIND_LOAD, 2'($urandom_range(0, 3)), rand_coord(),
                     rand_coord(), rand_coord());
        1: load_std_camera(rand_coord(), rand_coord(), rand_coord());
        2: send_item(w2s_pkg::KIND_PROJ, 2'($urandom_range(0, 3)), rand_coord(),
                     rand_coord(), rand_coord());
        default: send_item(w2s_pkg::KIND_PROJ, 2'($urandom_range(0, 3)), rand_coord(),
                           rand_coord(), camera[11] + rand_depth());
      endcase
    end
  endtask

  task automatic test_backpressure();
    load_std_camera(0, 0, 0);
    @(negedge clk);
    hold_req = 1'b1;
    for (int i = 0; i < 150; i++) begin
      send_item(w2s_pkg::KIND_PROJ, 2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                rand_depth());
    end
  endtask

  initial begin
    for (int i = 0; i < 12; i++) camera[i] = '0;
    scr_w = w2s_pkg::WIDTH_RST;
    scr_h = w2s_pkg::HEIGHT_RST;
    foc_x = w2s_pkg::FOCAL_RST;
    foc_y = w2s_pkg::FOCAL_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_unloaded_camera();
    test_directed();
    test_screen_settings();
    test_random(320);
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
